// ----- hdl/gdad_pkg.sv -----
// Package for the Gregorian date add/diff unit: constants, types, calendar helpers.
// No dependencies; used by every module in hdl/.
package gdad_pkg;

	localparam int unsigned MaxYearDefault = 9999;
	localparam int unsigned YearW = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW = 5;
	localparam int unsigned OffW = 23;
	localparam int unsigned DnW = 26;     // day numbers up to 65535 years, plus sign
	localparam int unsigned DiffMax = 4194303;

	localparam logic [1:0] OrdEarlier = 2'd0;
	localparam logic [1:0] OrdEqual = 2'd1;
	localparam logic [1:0] OrdLater = 2'd2;

	// Gregorian leap test; y / 100 by reciprocal multiply, exact for 17-bit years
	function automatic logic is_leap(input logic [16:0] y);
		logic [34:0] prod;
		logic [10:0] q100;
		logic [16:0] r100;
		begin
			prod = 35'(y) * 35'd167773;
			q100 = prod[34:24];
			r100 = y - 17'(q100) * 17'd100;
			// divisible by 400 = divisible by 100 with a quotient divisible by 4
			is_leap = ((y[1:0] == 2'd0) && (r100 != 17'd0)) ||
				((r100 == 17'd0) && (q100[1:0] == 2'd0));
		end
	endfunction

	// Month length, zero for month codes outside 1..12
	function automatic logic [DayW-1:0] month_len(input logic [16:0] y,
			input logic [MonthW-1:0] m);
		begin
			unique case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
				4'd2: month_len = is_leap(y) ? 5'd29 : 5'd28;
				default: month_len = 5'd0;
			endcase
		end
	endfunction

	typedef struct packed {
		logic start;
		logic done;
	} gdad_ctl_t;

endpackage

// ----- hdl/gdad_conv.sv -----
// Iterative date <-> day-number converter for the date add/diff unit.
// Depends on gdad_pkg. One shared adder/compare walks years by 400/100/4/1 and months.
module gdad_conv (
	input  logic clk,
	input  logic arst_n,
	input  gdad_pkg::gdad_ctl_t ctl_in,     // start pulse in; done unused
	input  logic to_date,                   // 1: day number to date, 0: date to number
	input  logic [16:0] year_in,
	input  logic [gdad_pkg::MonthW-1:0] month_in,
	input  logic [gdad_pkg::DayW-1:0] day_in,
	input  logic [gdad_pkg::DnW-1:0] dn_in,
	output gdad_pkg::gdad_ctl_t ctl_out,    // done pulse out
	output logic [gdad_pkg::DnW-1:0] dn_out,
	output logic [16:0] year_out,
	output logic [gdad_pkg::MonthW-1:0] month_out,
	output logic [gdad_pkg::DayW-1:0] day_out
);
	typedef enum logic [2:0] {S_IDLE, S_YEARS, S_MONTHS, S_DAY} st_t;
	st_t st_q;
	logic dir_q;
	logic [gdad_pkg::DnW-1:0] acc_q;     // day count accumulated or remaining
	logic [16:0] yr_q;                   // years remaining (to number) / built year (to date)
	logic [gdad_pkg::MonthW-1:0] mo_q, mtgt_q;
	logic [gdad_pkg::DayW-1:0] dy_q;
	logic [1:0] lvl_q;                   // 400 / 100 / 4 / 1 year step
	logic [2:0] cnt_q;                   // steps taken at the century/year levels

	logic [gdad_pkg::DnW-1:0] step_days;
	logic [16:0] step_years;
	logic [gdad_pkg::DnW-1:0] ml_ext;
	logic [16:0] leap_year;

	// step size for the current level
	always_comb begin
		unique case (lvl_q)
			2'd0: begin step_days = 26'd146097; step_years = 17'd400; end
			2'd1: begin step_days = 26'd36524; step_years = 17'd100; end
			2'd2: begin step_days = 26'd1461; step_years = 17'd4; end
			default: begin step_days = 26'd365; step_years = 17'd1; end
		endcase
		leap_year = dir_q ? yr_q + 17'd1 : year_out;
		ml_ext = gdad_pkg::DnW'(gdad_pkg::month_len(leap_year, mo_q));
	end

	assign dn_out = acc_q;
	assign month_out = mo_q;
	assign day_out = dy_q;
	always_comb year_out = dir_q ? yr_q + 17'd1 : year_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ctl_out <= '0;
			dir_q <= 1'b0;
			acc_q <= '0; yr_q <= '0; mo_q <= '0; mtgt_q <= '0; dy_q <= '0;
			lvl_q <= '0; cnt_q <= '0;
		end else begin
			ctl_out <= '0;
			unique case (st_q)
				S_IDLE: begin
					if (ctl_in.start) begin
						dir_q <= to_date;
						lvl_q <= 2'd0;
						cnt_q <= '0;
						mo_q <= 4'd1;
						mtgt_q <= month_in;
						dy_q <= day_in;
						if (to_date) begin
							acc_q <= dn_in; yr_q <= '0;
						end else begin
							acc_q <= '0; yr_q <= year_in - 17'd1;
						end
						st_q <= S_YEARS;
					end
				end
				// one year-block per cycle, largest blocks first
				S_YEARS: begin
					if (!dir_q) begin
						if (yr_q >= step_years) begin
							yr_q <= yr_q - step_years;
							acc_q <= acc_q + step_days;
						end else if (lvl_q == 2'd3) st_q <= S_MONTHS;
						else lvl_q <= lvl_q + 2'd1;
					end else begin
						// at most 3 centuries and 3 single years per block
						if (acc_q >= step_days && (lvl_q == 2'd0 || lvl_q == 2'd2 ||
								cnt_q != 3'd3)) begin
							acc_q <= acc_q - step_days;
							yr_q <= yr_q + step_years;
							cnt_q <= cnt_q + 3'd1;
						end else begin
							cnt_q <= '0;
							if (lvl_q == 2'd3) st_q <= S_MONTHS;
							else lvl_q <= lvl_q + 2'd1;
						end
					end
				end
				// one month per cycle
				S_MONTHS: begin
					if (!dir_q) begin
						if (mo_q < mtgt_q && mo_q <= 4'd12) begin
							acc_q <= acc_q + ml_ext;
							mo_q <= mo_q + 4'd1;
						end else st_q <= S_DAY;
					end else begin
						if (acc_q >= ml_ext && mo_q < 4'd12) begin
							acc_q <= acc_q - ml_ext;
							mo_q <= mo_q + 4'd1;
						end else st_q <= S_DAY;
					end
				end
				default: begin
					if (!dir_q) acc_q <= acc_q + gdad_pkg::DnW'(dy_q) - 26'd1;
					else dy_q <= gdad_pkg::DayW'(acc_q) + 5'd1;
					ctl_out.done <= 1'b1;
					st_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- hdl/gregorian_date_add_and_diff_unit.sv -----
// Top level of the Gregorian date add/diff unit: stream ports and sequencer.
// Depends on gdad_pkg and gdad_conv (shared iterative converter).
//
//  channel | dir | tdata fields (low bit first)                          | tuser
//  s_axis  | in  | a_year, a_month, a_day, b_year, b_month, b_day, off   | -
//  m_axis  | out | sum_year, sum_month, sum_day, sum_out_of_range,       | -
//          |     | day_difference, order, a_replaced, b_replaced         |
//
// One item runs three converter passes (A to day number, B to day number, sum
// back to a date); each pass spends one cycle per 400/100/4/1-year block and
// per month.
// s_axis_tready is high only while idle; the result register holds until taken,
// and a waiting result stalls only the load of the next result.
// arst_n clears the sequencer and the output valid.
module gregorian_date_add_and_diff_unit #(
	parameter int unsigned MAX_YEAR = gdad_pkg::MaxYearDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_year[13:0] a_month[17:14] a_day[22:18] b_year[36:23] b_month[40:37]
	// b_day[45:41] day_offset[68:46], zero fill to 72
	input  logic [71:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// sum_year[13:0] sum_month[17:14] sum_day[22:18] sum_out_of_range[23]
	// day_difference[46:24] order[48:47] a_replaced[49] b_replaced[50], zero fill to 56
	output logic [55:0] m_axis_tdata
);
	typedef enum logic [2:0] {S_IDLE, S_CONV_A, S_CONV_B, S_CLAMP, S_CONV_S, S_OUT} st_t;
	localparam logic [gdad_pkg::DnW-1:0] LastDn = gdad_pkg::DnW'(
		365 * (MAX_YEAR - 1) + (MAX_YEAR - 1) / 4 - (MAX_YEAR - 1) / 100
		+ (MAX_YEAR - 1) / 400 + 364 + ((MAX_YEAR % 4 == 0 && MAX_YEAR % 100 != 0)
		|| MAX_YEAR % 400 == 0 ? 1 : 0));
	localparam logic [16:0] MaxY = 17'(MAX_YEAR);

	st_t st_q;
	logic [16:0] ay_q, by_q;
	logic [3:0] am_q, bm_q;
	logic [4:0] ad_q, bd_q;
	logic arep_q, brep_q, oor_q;
	logic signed [gdad_pkg::OffW-1:0] off_q;
	logic [gdad_pkg::DnW-1:0] na_q;
	logic signed [gdad_pkg::DnW:0] ns_q;
	logic [22:0] diff_q;
	logic [1:0] ord_q;
	logic [55:0] out_q;
	logic ovalid_q;
	logic start_q;

	gdad_pkg::gdad_ctl_t cs, cd;
	logic c_dir;
	logic [16:0] c_y, cy_o;
	logic [3:0] c_m, cm_o;
	logic [4:0] c_d, cd_o;
	logic [gdad_pkg::DnW-1:0] cdn_o;

	logic [13:0] iy_a, iy_b;
	logic [3:0] im_a, im_b;
	logic [4:0] id_a, id_b;
	logic va, vb;
	logic signed [gdad_pkg::DnW:0] diff;
	logic [22:0] diff_sat;
	logic [1:0] ord;

	assign iy_a = s_axis_tdata[13:0];  assign im_a = s_axis_tdata[17:14];
	assign id_a = s_axis_tdata[22:18]; assign iy_b = s_axis_tdata[36:23];
	assign im_b = s_axis_tdata[40:37]; assign id_b = s_axis_tdata[45:41];

	// validity of both input dates
	always_comb begin
		va = iy_a != 14'd0 && 17'(iy_a) <= MaxY && im_a >= 4'd1 && im_a <= 4'd12 &&
			id_a >= 5'd1 && id_a <= gdad_pkg::month_len(17'(iy_a), im_a);
		vb = iy_b != 14'd0 && 17'(iy_b) <= MaxY && im_b >= 4'd1 && im_b <= 4'd12 &&
			id_b >= 5'd1 && id_b <= gdad_pkg::month_len(17'(iy_b), im_b);
	end

	// converter operand select; start comes from the registered pulse
	always_comb begin
		cs.start = start_q; cs.done = 1'b0;
		c_dir = 1'b0; c_y = ay_q; c_m = am_q; c_d = ad_q;
		unique case (st_q)
			S_CONV_B: begin c_y = by_q; c_m = bm_q; c_d = bd_q; end
			S_CONV_S: c_dir = 1'b1;
			default: ;
		endcase
	end

	gdad_conv u_conv (
		.clk(clk), .arst_n(arst_n), .ctl_in(cs), .to_date(c_dir),
		.year_in(c_y), .month_in(c_m), .day_in(c_d), .dn_in(ns_q[gdad_pkg::DnW-1:0]),
		.ctl_out(cd), .dn_out(cdn_o), .year_out(cy_o), .month_out(cm_o), .day_out(cd_o)
	);

	// difference, saturation and order
	always_comb begin
		diff = $signed({1'b0, na_q}) - $signed({1'b0, cdn_o});
		if (diff > $signed(27'(gdad_pkg::DiffMax))) diff_sat = 23'h3FFFFF;
		else if (diff < -$signed(27'(gdad_pkg::DiffMax)) - 27'sd1) diff_sat = 23'h400000;
		else diff_sat = diff[22:0];
		if (diff < 0) ord = gdad_pkg::OrdEarlier;
		else if (diff == 0) ord = gdad_pkg::OrdEqual;
		else ord = gdad_pkg::OrdLater;
	end

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ovalid_q <= 1'b0; start_q <= 1'b0;
			ay_q <= '0; am_q <= '0; ad_q <= '0; by_q <= '0; bm_q <= '0; bd_q <= '0;
			arep_q <= 1'b0; brep_q <= 1'b0; oor_q <= 1'b0; off_q <= '0;
			na_q <= '0; ns_q <= '0; diff_q <= '0; ord_q <= '0; out_q <= '0;
		end else begin
			// converter start after accept, after pass A and after the clamp
			start_q <= (st_q == S_IDLE && s_axis_tvalid) || (st_q == S_CONV_A && cd.done) ||
				(st_q == S_CLAMP);
			// output valid: set on load, cleared when taken
			if (st_q == S_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					ay_q <= va ? 17'(iy_a) : 17'd1900; am_q <= va ? im_a : 4'd1;
					ad_q <= va ? id_a : 5'd1;
					by_q <= vb ? 17'(iy_b) : 17'd1900; bm_q <= vb ? im_b : 4'd1;
					bd_q <= vb ? id_b : 5'd1;
					arep_q <= !va; brep_q <= !vb;
					off_q <= s_axis_tdata[68:46];
					st_q <= S_CONV_A;
				end
				S_CONV_A: if (cd.done) begin
					na_q <= cdn_o;
					ns_q <= $signed({1'b0, cdn_o}) + 27'(off_q);
					st_q <= S_CONV_B;
				end
				S_CONV_B: if (cd.done) begin
					diff_q <= diff_sat; ord_q <= ord;
					st_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (ns_q < 0) begin ns_q <= '0; oor_q <= 1'b1; end
					else if (ns_q > $signed({1'b0, LastDn})) begin
						ns_q <= $signed({1'b0, LastDn}); oor_q <= 1'b1;
					end else oor_q <= 1'b0;
					st_q <= S_CONV_S;
				end
				S_CONV_S: if (cd.done) st_q <= S_OUT;
				// converter outputs hold while idle; load once the old result is gone
				default: if (!ovalid_q || m_axis_tready) begin
					out_q <= {5'd0, brep_q, arep_q, ord_q, diff_q, oor_q, cd_o, cm_o,
						cy_o[13:0]};
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[48:47] != 2'd3)) else $error("bad order code");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[17:14] >= 4'd1 && m_axis_tdata[17:14] <= 4'd12))
		else $error("sum month out of range");
endmodule
